[rtl/assert_macros.svh]
// Assertion helpers for the ordered state table.
// Both take a label, a clock, a reset that disables the check, an antecedent
// and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/okst_pkg.sv]
package okst_pkg;

  localparam int ENTRIES     = 16;
  localparam int LIST_MAX    = 16;
  localparam int MAX_RESULTS = 16;
  localparam int LIST_CAP    = (LIST_MAX < MAX_RESULTS) ? LIST_MAX : MAX_RESULTS;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int LCNT_W = $clog2(LIST_CAP + 1);

  localparam int CODE_W  = 8;
  localparam int TOTAL_W = 5;
  localparam int REG_W   = 8;

  // Configuration register indexes
  localparam logic [REG_W-1:0] REG_IDLE   = 8'd0;
  localparam logic [REG_W-1:0] REG_STOP   = 8'd1;
  localparam logic [REG_W-1:0] REG_MANUAL = 8'd2;

  typedef enum logic [2:0] {
    OUT_INSERTED  = 3'd0,
    OUT_UPDATED   = 3'd1,
    OUT_DELETED   = 3'd2,
    OUT_NOT_FOUND = 3'd3,
    OUT_FULL      = 3'd4,
    OUT_LIST      = 3'd5
  } outcome_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_UPDATE,
    OP_DELETE,
    OP_APPEND,
    OP_ROTATE
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REC,
    S_LIST
  } state_t;

  typedef struct packed {
    logic [CODE_W-1:0] kind;
    logic [CODE_W-1:0] ident;
    logic [CODE_W-1:0] run_state;
  } entry_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] kind;
    logic [CODE_W-1:0] ident;
    logic [CODE_W-1:0] run_state;
    logic [CNT_W-1:0]  total;
  } cell_cmd_t;

endpackage

[rtl/okst_cell.sv]
module okst_cell (
  input  logic                         clk,
  input  okst_pkg::cell_cmd_t          cmd,
  input  logic [okst_pkg::IDX_W-1:0]   index,
  input  logic                         hit_in,
  input  okst_pkg::entry_t             nb_entry,
  input  okst_pkg::entry_t             wrap_entry,
  output okst_pkg::entry_t             entry,
  output logic                         hit_out
);

  logic occupied;
  logic own_match;
  logic first;
  logic at_total;
  logic tail;
  okst_pkg::entry_t entry_next;

  assign occupied  = okst_pkg::CNT_W'(index) < cmd.total;
  assign own_match = occupied && (entry.kind == cmd.kind) && (entry.ident == cmd.ident);
  assign hit_out   = hit_in || own_match;
  assign first     = own_match && !hit_in;
  assign at_total  = okst_pkg::CNT_W'(index) == cmd.total;
  assign tail      = (okst_pkg::CNT_W'(index) + okst_pkg::CNT_W'(1)) == cmd.total;

  always_comb begin
    entry_next = entry;
    unique case (cmd.op)
      okst_pkg::OP_HOLD: ;
      okst_pkg::OP_UPDATE: begin
        if (first) entry_next.run_state = cmd.run_state;
      end
      // close the gap: everything from the match onwards moves up one place
      okst_pkg::OP_DELETE: begin
        if (hit_out) entry_next = nb_entry;
      end
      okst_pkg::OP_APPEND: begin
        if (at_total) begin
          entry_next.kind      = cmd.kind;
          entry_next.ident     = cmd.ident;
          entry_next.run_state = cmd.run_state;
        end
      end
      okst_pkg::OP_ROTATE: begin
        entry_next = tail ? wrap_entry : nb_entry;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[rtl/ordered_keyed_state_table_unit.sv]
// Ordered keyed state table. Holds up to ENTRIES (kind, ident, run state)
// entries in insertion order, one per cell of a chain; every cell compares
// its key against the broadcast key and a first-match flag ripples down the
// chain. A record transfer is accepted in the idle state; then, in the
// record state, the chain resolves the first match and updates, appends or
// deletes (deletion shifts every later cell up one place in that same
// cycle). In a list transfer the occupied part of the chain rotates by
// one cell per cycle past cell 0, which is inspected, so after entry_total
// steps the table is back in order; listed idents come out one per cycle at
// most, the final one flagged by last. Cycles in which the result register
// is full and not taken stall all progress. A new input transfer is taken
// only when the previous one has produced all its results, though the last
// result may still be waiting in the output register. Configuration writes
// are always accepted; indexes beyond 2 are ignored.
`include "assert_macros.svh"

module ordered_keyed_state_table_unit (
  input  logic       clk,
  input  logic       rst,
  // input item
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       action,
  input  logic [7:0] kind,
  input  logic [7:0] ident,
  input  logic [7:0] run_state,
  // result item
  output logic       out_valid,
  input  logic       out_ready,
  output logic       item_valid,
  output logic [7:0] listed_id,
  output logic       last,
  output logic [2:0] outcome,
  output logic [4:0] entry_total,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int N = okst_pkg::ENTRIES;

  okst_pkg::state_t state, state_next;

  // configuration registers
  logic [7:0] idle_code, stop_code, manual_code;

  // held input item
  logic [7:0] kind_q, ident_q, rs_q;

  // table occupancy and list scan
  logic [okst_pkg::CNT_W-1:0]  total, total_next;
  logic [okst_pkg::CNT_W-1:0]  pos, pos_next;
  logic [okst_pkg::LCNT_W-1:0] lcnt, lcnt_next;
  logic [7:0]                  pend_id, pend_id_next;
  logic                        has_pend, has_pend_next;

  // result register
  logic                   out_valid_next;
  logic                   out_item_valid, out_item_valid_next;
  logic [7:0]             out_id, out_id_next;
  logic                   out_last, out_last_next;
  okst_pkg::outcome_t     out_outcome, out_outcome_next;
  logic [4:0]             out_total, out_total_next;

  okst_pkg::cell_cmd_t cmd;
  okst_pkg::entry_t    entries [N];
  logic [N:0]          hit;

  logic can_emit;
  logic is_del;
  logic found;
  logic sel0;
  logic rec_step;
  logic append_step;

  assign cfg_ready = 1'b1;

  // -------------------------------------------------------------------------
  // Chain of cells. Each hands its entry to the one before it on a delete or
  // rotate step; the last occupied cell takes cell 0's entry when rotating.
  // -------------------------------------------------------------------------
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    okst_pkg::entry_t nb;
    if (i == N - 1) begin : g_end
      assign nb = entries[i];
    end else begin : g_mid
      assign nb = entries[i + 1];
    end
    okst_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .index      (okst_pkg::IDX_W'(i)),
      .hit_in     (hit[i]),
      .nb_entry   (nb),
      .wrap_entry (entries[0]),
      .entry      (entries[i]),
      .hit_out    (hit[i + 1])
    );
  end

  assign can_emit = !out_valid || out_ready;
  assign is_del   = (rs_q == idle_code) || (rs_q == stop_code);
  assign found    = hit[N];
  assign sel0     = (entries[0].kind == 8'd0) && (entries[0].run_state == manual_code);

  assign in_ready = (state == okst_pkg::S_IDLE);

  // -------------------------------------------------------------------------
  // Control: next state, cell command and result register load
  // -------------------------------------------------------------------------
  always_comb begin
    state_next          = state;
    total_next          = total;
    pos_next            = pos;
    lcnt_next           = lcnt;
    pend_id_next        = pend_id;
    has_pend_next       = has_pend;
    out_valid_next      = out_valid && !out_ready;
    out_item_valid_next = out_item_valid;
    out_id_next         = out_id;
    out_last_next       = out_last;
    out_outcome_next    = out_outcome;
    out_total_next      = out_total;

    cmd.op        = okst_pkg::OP_HOLD;
    cmd.kind      = kind_q;
    cmd.ident     = ident_q;
    cmd.run_state = rs_q;
    cmd.total     = total;

    unique case (state)
      okst_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next    = action ? okst_pkg::S_LIST : okst_pkg::S_REC;
          pos_next      = '0;
          lcnt_next     = '0;
          has_pend_next = 1'b0;
        end
      end

      okst_pkg::S_REC: begin
        if (can_emit) begin
          if (is_del) begin
            if (found) begin
              cmd.op           = okst_pkg::OP_DELETE;
              total_next       = total - okst_pkg::CNT_W'(1);
              out_outcome_next = okst_pkg::OUT_DELETED;
            end else begin
              out_outcome_next = okst_pkg::OUT_NOT_FOUND;
            end
          end else if (found) begin
            cmd.op           = okst_pkg::OP_UPDATE;
            out_outcome_next = okst_pkg::OUT_UPDATED;
          end else if (total < okst_pkg::CNT_W'(N)) begin
            cmd.op           = okst_pkg::OP_APPEND;
            total_next       = total + okst_pkg::CNT_W'(1);
            out_outcome_next = okst_pkg::OUT_INSERTED;
          end else begin
            out_outcome_next = okst_pkg::OUT_FULL;
          end
          out_valid_next      = 1'b1;
          out_item_valid_next = 1'b0;
          out_id_next         = 8'd0;
          out_last_next       = 1'b1;
          out_total_next      = 5'(total_next);
          state_next          = okst_pkg::S_IDLE;
        end
      end

      okst_pkg::S_LIST: begin
        if (can_emit) begin
          out_outcome_next = okst_pkg::OUT_LIST;
          out_total_next   = 5'(total);
          if (pos < total) begin
            // inspect cell 0, then advance the ring by one cell
            cmd.op   = okst_pkg::OP_ROTATE;
            pos_next = pos + okst_pkg::CNT_W'(1);
            if (sel0 && (lcnt < okst_pkg::LCNT_W'(okst_pkg::LIST_CAP))) begin
              lcnt_next     = lcnt + okst_pkg::LCNT_W'(1);
              pend_id_next  = entries[0].ident;
              has_pend_next = 1'b1;
              // a later match proves the held one is not the final result
              if (has_pend) begin
                out_valid_next      = 1'b1;
                out_item_valid_next = 1'b1;
                out_id_next         = pend_id;
                out_last_next       = 1'b0;
              end
            end
          end else begin
            out_valid_next      = 1'b1;
            out_item_valid_next = has_pend;
            out_id_next         = has_pend ? pend_id : 8'd0;
            out_last_next       = 1'b1;
            has_pend_next       = 1'b0;
            state_next          = okst_pkg::S_IDLE;
          end
        end
      end

      default: state_next = okst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= okst_pkg::S_IDLE;
      total     <= '0;
      out_valid <= 1'b0;
      has_pend  <= 1'b0;
    end else begin
      state     <= state_next;
      total     <= total_next;
      out_valid <= out_valid_next;
      has_pend  <= has_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_code   <= 8'd0;
      stop_code   <= 8'd1;
      manual_code <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        okst_pkg::REG_IDLE:   idle_code   <= cfg_data;
        okst_pkg::REG_STOP:   stop_code   <= cfg_data;
        okst_pkg::REG_MANUAL: manual_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_q  <= kind;
      ident_q <= ident;
      rs_q    <= run_state;
    end
    pos            <= pos_next;
    lcnt           <= lcnt_next;
    pend_id        <= pend_id_next;
    out_item_valid <= out_item_valid_next;
    out_id         <= out_id_next;
    out_last       <= out_last_next;
    out_outcome    <= out_outcome_next;
    out_total      <= out_total_next;
  end

  assign item_valid  = out_item_valid;
  assign listed_id   = out_id;
  assign last        = out_last;
  assign outcome     = out_outcome;
  assign entry_total = out_total;

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  assign rec_step    = (state == okst_pkg::S_REC) && can_emit;
  assign append_step = rec_step && (cmd.op == okst_pkg::OP_APPEND);

  `ASSERT_IMPL(a_total_bound, clk, rst, 1'b1, total <= okst_pkg::CNT_W'(N))
  `ASSERT_IMPL(a_scan_bound, clk, rst, state == okst_pkg::S_LIST, pos <= total)
  `ASSERT_NEXT(a_rec_result, clk, rst, rec_step, out_valid && out_last && !out_item_valid)
  `ASSERT_NEXT(a_append_grow, clk, rst, append_step, total == $past(total) + okst_pkg::CNT_W'(1))

endmodule

[tb/sv/ordered_table_checker.sv]
`default_nettype none

module ordered_table_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic       action,
  input  wire logic [7:0] kind,
  input  wire logic [7:0] ident,
  input  wire logic [7:0] run_state,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic       item_valid,
  input  wire logic [7:0] listed_id,
  input  wire logic       last,
  input  wire logic [2:0] outcome,
  input  wire logic [4:0] entry_total,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_ready,
  input  wire logic [7:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output int              fail_count,
  output int              results_due
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       ACT_LIST        = 1'b1;
  localparam logic [7:0] IDLE_AT_RESET   = 8'd0;
  localparam logic [7:0] STOP_AT_RESET   = 8'd1;
  localparam logic [7:0] MANUAL_AT_RESET = 8'd2;

  typedef struct packed {
    logic               item_valid;
    logic [7:0]         listed_id;
    logic               last;
    okst_pkg::outcome_t outcome;
    logic [4:0]         entry_total;
  } table_result_t;

  // shadow copy of the table and of the code registers
  logic [7:0] shadow_kind  [okst_pkg::ENTRIES];
  logic [7:0] shadow_ident [okst_pkg::ENTRIES];
  logic [7:0] shadow_state [okst_pkg::ENTRIES];
  int         shadow_count;
  logic [7:0] idle_code, stop_code, manual_code;

  table_result_t      due_results[$];
  table_result_t      want, r;
  logic [7:0]         listed_ids [okst_pkg::LIST_CAP];
  okst_pkg::outcome_t oc;
  int                 fails;
  int                 i, n, hit;

  initial begin
    fails       = 0;
    fail_count  = 0;
    results_due = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      shadow_count = 0;
      idle_code    = IDLE_AT_RESET;
      stop_code    = STOP_AT_RESET;
      manual_code  = MANUAL_AT_RESET;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          okst_pkg::REG_IDLE:   idle_code   = cfg_data;
          okst_pkg::REG_STOP:   stop_code   = cfg_data;
          okst_pkg::REG_MANUAL: manual_code = cfg_data;
          default: ;
        endcase
      end

      // compare the result transfer with the oldest expectation
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result transfer with nothing expected: outcome %0d id %0d",
                 outcome, listed_id);
          fails++;
        end else begin
          want = due_results.pop_front();
          if (item_valid !== want.item_valid) begin
            $error("item_valid: expected %0d, got %0d", want.item_valid, item_valid);
            fails++;
          end
          if (listed_id !== want.listed_id) begin
            $error("listed_id: expected %0d, got %0d", want.listed_id, listed_id);
            fails++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            fails++;
          end
          if (outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, outcome);
            fails++;
          end
          if (entry_total !== want.entry_total) begin
            $error("entry_total: expected %0d, got %0d", want.entry_total, entry_total);
            fails++;
          end
        end
      end

      // predict the results of an accepted input transfer
      if (in_valid && in_ready) begin
        if (action == ACT_LIST) begin
          n = 0;
          for (i = 0; i < shadow_count; i++) begin
            if (n < okst_pkg::LIST_CAP && shadow_kind[i] == 8'd0 &&
                shadow_state[i] == manual_code) begin
              listed_ids[n] = shadow_ident[i];
              n++;
            end
          end
          r.outcome     = okst_pkg::OUT_LIST;
          r.entry_total = 5'(shadow_count);
          if (n == 0) begin
            r.item_valid = 1'b0;
            r.listed_id  = 8'd0;
            r.last       = 1'b1;
            due_results.push_back(r);
          end else begin
            for (i = 0; i < n; i++) begin
              r.item_valid = 1'b1;
              r.listed_id  = listed_ids[i];
              r.last       = (i == n - 1);
              due_results.push_back(r);
            end
          end
        end else begin
          hit = -1;
          for (i = 0; i < shadow_count; i++)
            if (hit < 0 && shadow_kind[i] == kind && shadow_ident[i] == ident) hit = i;
          if (run_state == idle_code || run_state == stop_code) begin
            if (hit >= 0) begin
              // close the gap so the order is kept
              for (i = hit; i < shadow_count - 1; i++) begin
                shadow_kind[i]  = shadow_kind[i+1];
                shadow_ident[i] = shadow_ident[i+1];
                shadow_state[i] = shadow_state[i+1];
              end
              shadow_count--;
              oc = okst_pkg::OUT_DELETED;
            end else begin
              oc = okst_pkg::OUT_NOT_FOUND;
            end
          end else if (hit >= 0) begin
            shadow_state[hit] = run_state;
            oc = okst_pkg::OUT_UPDATED;
          end else if (shadow_count < okst_pkg::ENTRIES) begin
            shadow_kind[shadow_count]  = kind;
            shadow_ident[shadow_count] = ident;
            shadow_state[shadow_count] = run_state;
            shadow_count++;
            oc = okst_pkg::OUT_INSERTED;
          end else begin
            oc = okst_pkg::OUT_FULL;
          end
          r.item_valid  = 1'b0;
          r.listed_id   = 8'd0;
          r.last        = 1'b1;
          r.outcome     = oc;
          r.entry_total = 5'(shadow_count);
          due_results.push_back(r);
        end
      end
    end
    results_due <= due_results.size();
    fail_count  <= fails;
  end

endmodule

`default_nettype wire

[tb/sv/ordered_keyed_state_table_unit_test.sv]
`default_nettype none

module ordered_keyed_state_table_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       ACT_RECORD      = 1'b0;
  localparam logic       ACT_LIST        = 1'b1;
  localparam logic [7:0] IDLE_AT_RESET   = 8'd0;
  localparam logic [7:0] STOP_AT_RESET   = 8'd1;
  localparam logic [7:0] MANUAL_AT_RESET = 8'd2;
  localparam int         PHASES          = 6;
  localparam int         PHASE_ITEMS     = 40;
  // far beyond the slowest legal run: every list item giving 16 results,
  // each stalled by the receiver, plus sender gaps and settling pauses
  localparam int         CYCLE_LIMIT     = 400000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       action = ACT_RECORD;
  logic [7:0] kind = 8'd0;
  logic [7:0] ident = 8'd0;
  logic [7:0] run_state = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       item_valid;
  logic [7:0] listed_id;
  logic       last;
  logic [2:0] outcome;
  logic [4:0] entry_total;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = 8'd0;
  logic [7:0] cfg_data = 8'd0;

  int fail_count;
  int results_due;
  int cycles = 0;

  // chance in a hundred that the sender pauses / the receiver stalls
  int gap_pct   = 25;
  int stall_pct = 25;

  // codes currently held by the block, used to steer the random items
  logic [7:0] cur_idle   = IDLE_AT_RESET;
  logic [7:0] cur_stop   = STOP_AT_RESET;
  logic [7:0] cur_manual = MANUAL_AT_RESET;

  ordered_keyed_state_table_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .kind        (kind),
    .ident       (ident),
    .run_state   (run_state),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .item_valid  (item_valid),
    .listed_id   (listed_id),
    .last        (last),
    .outcome     (outcome),
    .entry_total (entry_total),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  ordered_table_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .kind        (kind),
    .ident       (ident),
    .run_state   (run_state),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .item_valid  (item_valid),
    .listed_id   (listed_id),
    .last        (last),
    .outcome     (outcome),
    .entry_total (entry_total),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: drop ready at random, one fresh decision per cycle.
  initial begin
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Watchdog: end the run if the block hangs.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("ordered_keyed_state_table_unit: mismatch");
    $finish;
  end

  // Present one item and hold it until the transfer. Valid is only lowered
  // when a gap is chosen, so a back-to-back item never sees valid drop and
  // rise in the same step. Valid is left high on return.
  task automatic send_item(input logic a, input logic [7:0] k, input logic [7:0] id,
                           input logic [7:0] rs);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < 50) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= a;
    kind      <= k;
    ident     <= id;
    run_state <= rs;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every expected result has been taken, then
  // give the block time to finish any list rotation still under way.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (okst_pkg::ENTRIES + 4) @(posedge clk);
  endtask

  // Write all three code registers while idle, plus one write to an index
  // the block must ignore.
  task automatic configure(input logic [7:0] idle_v, input logic [7:0] stop_v,
                           input logic [7:0] manual_v);
    logic [7:0] idx [4];
    logic [7:0] dat [4];
    idx[0] = okst_pkg::REG_IDLE;
    dat[0] = idle_v;
    idx[1] = okst_pkg::REG_STOP;
    dat[1] = stop_v;
    idx[2] = okst_pkg::REG_MANUAL;
    dat[2] = manual_v;
    idx[3] = 8'($urandom_range(int'(okst_pkg::REG_MANUAL) + 1, 255));
    dat[3] = 8'($urandom);
    settle();
    for (int w = 0; w < 4; w++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[w];
      cfg_data  <= dat[w];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid  <= 1'b0;
    cur_idle   = idle_v;
    cur_stop   = stop_v;
    cur_manual = manual_v;
  endtask

  initial begin
    logic [7:0] phase_idle   [PHASES];
    logic [7:0] phase_stop   [PHASES];
    logic [7:0] phase_manual [PHASES];
    int         phase_pool   [PHASES];
    logic [7:0] salt, k, id, rs;
    int         pick;

    // extremes, all three codes equal, manual equal to stop, random codes
    phase_idle   = '{8'd255, 8'd9, 8'd0,   8'($urandom), 8'd128, 8'($urandom)};
    phase_stop   = '{8'd0,   8'd9, 8'd255, 8'($urandom), 8'd3,   8'($urandom)};
    phase_manual = '{8'd254, 8'd9, 8'd1,   8'($urandom), 8'd3,   8'($urandom)};
    phase_pool   = '{20, 6, 12, 24, 8, 16};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset codes.
    send_item(ACT_LIST, 8'($urandom), 8'($urandom), 8'($urandom));   // list of empty table
    send_item(ACT_RECORD, 8'd0, 8'd0, IDLE_AT_RESET);                // delete, no match
    send_item(ACT_RECORD, 8'd0, 8'd0, MANUAL_AT_RESET);
    send_item(ACT_RECORD, 8'd0, 8'd255, MANUAL_AT_RESET);
    send_item(ACT_RECORD, 8'd255, 8'd1, MANUAL_AT_RESET);            // wrong kind for list
    send_item(ACT_RECORD, 8'd0, 8'd7, 8'd255);
    send_item(ACT_LIST, 8'd255, 8'd255, 8'd255);
    send_item(ACT_RECORD, 8'd0, 8'd7, MANUAL_AT_RESET);              // update in place
    send_item(ACT_RECORD, 8'd0, 8'd255, STOP_AT_RESET);              // delete from the middle
    send_item(ACT_LIST, 8'd0, 8'd0, 8'd0);
    for (int j = 0; j < 13; j++)
      send_item(ACT_RECORD, 8'd0, 8'(16 + j), MANUAL_AT_RESET);      // fill the table
    send_item(ACT_RECORD, 8'h80, 8'h80, MANUAL_AT_RESET);            // full, dropped
    send_item(ACT_RECORD, 8'd255, 8'd1, IDLE_AT_RESET);
    send_item(ACT_RECORD, 8'd0, 8'd200, MANUAL_AT_RESET);
    send_item(ACT_LIST, 8'd0, 8'd0, 8'd0);                           // list at the cap
    send_item(ACT_RECORD, 8'd0, 8'd0, STOP_AT_RESET);                // delete the head

    // Hold off until the block has drained before the first random phase.
    settle();

    for (int p = 0; p < PHASES; p++) begin
      configure(phase_idle[p], phase_stop[p], phase_manual[p]);
      // phase 2 runs flat out on both sides
      gap_pct   = (p == 2) ? 0 : 25;
      stall_pct = (p == 2) ? 0 : 25;
      salt = 8'($urandom);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
          send_item(ACT_LIST, 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          // mostly keys from a small pool so records hit live entries;
          // the odd fully random key as noise
          if ($urandom_range(0, 9) == 0) begin
            k  = 8'($urandom);
            id = 8'($urandom);
          end else begin
            k  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 3)) : 8'd0;
            id = 8'($urandom_range(0, phase_pool[p] - 1)) ^ salt;
          end
          pick = $urandom_range(0, 99);
          if (pick < 18)      rs = cur_idle;
          else if (pick < 34) rs = cur_stop;
          else if (pick < 72) rs = cur_manual;
          else                rs = 8'($urandom);
          send_item(ACT_RECORD, k, id, rs);
        end
      end
    end

    settle();
    if (fail_count == 0)
      $display("ordered_keyed_state_table_unit: match");
    else
      $display("ordered_keyed_state_table_unit: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
